// ===== src/ffsa_pkg.sv =====
package ffsa_pkg;

	localparam logic [1:0] FN_CLEAR = 2'd0;
	localparam logic [1:0] FN_ALLOC = 2'd1;
	localparam logic [1:0] FN_FREE  = 2'd2;
	localparam logic [1:0] FN_UNDEF = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOSPACE  = 2'd1;
	localparam logic [1:0] ST_NOTALLOC = 2'd2;

	localparam logic [1:0] RS_ONE   = 2'd0;
	localparam logic [1:0] RS_TWO   = 2'd1;
	localparam logic [1:0] RS_FOUR  = 2'd2;
	localparam logic [1:0] RS_UNDEF = 2'd3;

	localparam logic [1:0] TAG_FREE = 2'd0;
	localparam logic [1:0] TAG_ONE  = 2'd1;
	localparam logic [1:0] TAG_TWO  = 2'd2;
	localparam logic [1:0] TAG_FOUR = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [1:0] run_size;
		logic [7:0] slot_index;
	} ffsa_req_t;

	typedef struct packed {
		logic [7:0] granted_index;
		logic [1:0] status;
		logic [8:0] high_water;
	} ffsa_rsp_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_SCAN,
		S_FILL,
		S_LOOKUP,
		S_CHECK,
		S_RELEASE,
		S_DONE
	} ffsa_state_t;

	// Run length minus one for a tag code: one slot 0, two slots 1, four slots 3.
	function automatic logic [1:0] tag_len_m1(input logic [1:0] tag);
		logic [1:0] r;
		case (tag)
			TAG_TWO:  r = 2'd1;
			TAG_FOUR: r = 2'd3;
			default:  r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/ffsa_tag_ram.sv =====
module ffsa_tag_ram import ffsa_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [1:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [1:0]    rdata
);

	logic [1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/first_fit_slot_allocator_unit.sv =====
// Clear writes every tag to free; allocate scans for a run, then fills it; free looks up
// a tag, checks it, releases its run; a bad operation, size or index goes to the result.
// Throughput: one item at a time; the first-fit scan reads one tag per cycle from the
// single read port of the tag memory.
// Reset: arst_n clears control state at once, then a clearing pass writes every tag to
// free, one slot per cycle, while req_ready stays low.
module first_fit_slot_allocator_unit import ffsa_pkg::*; #(
	parameter int SLOT_COUNT = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  ffsa_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output ffsa_rsp_t rsp
);

	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] SLOTS = CW'(SLOT_COUNT);
	localparam logic [AW-1:0] LAST  = AW'(SLOT_COUNT - 1);

	ffsa_state_t state_q, state_d;

	// The address counter is shared: it walks the pool during the scan,
	// the fill, the release and the clearing pass.
	logic [CW-1:0] cnt_q;
	logic          rd_pend_q;
	logic [AW-1:0] rd_addr_q;
	logic [2:0]    run_q;
	logic [1:0]    lenm1_q;
	logic [1:0]    code_q;
	logic [1:0]    rem_q;
	logic [7:0]    granted_q;
	logic [1:0]    status_q;
	logic [CW-1:0] used_q;
	ffsa_rsp_t     rsp_q;
	logic          rsp_valid_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [1:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [1:0]    ram_rdata;
	logic          rsp_load;
	logic          accept;

	logic          tag_free;
	logic [2:0]    run_nx;
	logic          hit;
	logic          scan_last;
	logic          scan_issue;
	logic [AW-1:0] hit_start;
	logic [CW-1:0] hit_end;
	logic          idx_ok;

	ffsa_tag_ram #(
		.DEPTH(SLOT_COUNT),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign accept = req_valid && req_ready;

	// A run is found when the slot that just came back is free and closes a free
	// stretch of the requested length. Its start lies lenm1 slots back.
	assign tag_free   = rd_pend_q && (ram_rdata == TAG_FREE);
	assign run_nx     = tag_free ? run_q + 3'd1 : 3'd0;
	assign hit        = tag_free && (run_q == {1'b0, lenm1_q});
	assign scan_last  = rd_pend_q && (rd_addr_q == LAST);
	assign scan_issue = (cnt_q < SLOTS) && !hit;
	assign hit_start  = rd_addr_q - AW'(lenm1_q);
	assign hit_end    = {1'b0, rd_addr_q} + CW'(1);
	assign idx_ok     = int'(req.slot_index) < SLOT_COUNT;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (cnt_q[AW-1:0] == LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					case (req.func)
						FN_CLEAR: state_d = S_CLEAR;
						FN_ALLOC: state_d = (req.run_size inside {RS_ONE, RS_TWO, RS_FOUR}) ?
							S_SCAN : S_DONE;
						FN_FREE:  state_d = idx_ok ? S_LOOKUP : S_DONE;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_CLEAR: begin
				if (cnt_q[AW-1:0] == LAST) state_d = S_DONE;
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_FILL;
				end else if (scan_last) begin
					state_d = S_DONE;
				end
			end
			S_FILL: begin
				if (rem_q == 2'd0) state_d = S_DONE;
			end
			S_LOOKUP: state_d = S_CHECK;
			S_CHECK: begin
				state_d = (ram_rdata == TAG_FREE) ? S_DONE : S_RELEASE;
			end
			S_RELEASE: begin
				if ((rem_q == 2'd0) || (cnt_q[AW-1:0] == LAST)) state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = TAG_FREE;
		ram_raddr = cnt_q[AW-1:0];
		rsp_load  = 1'b0;
		case (state_q)
			S_IDLE:    req_ready = 1'b1;
			S_INIT:    ram_we = 1'b1;
			S_CLEAR:   ram_we = 1'b1;
			S_RELEASE: ram_we = 1'b1;
			S_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = code_q;
			end
			S_DONE:    rsp_load = !rsp_valid_q || rsp_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			rd_pend_q   <= 1'b0;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			rd_pend_q <= 1'b0;
			case (state_q)
				S_INIT, S_CLEAR, S_FILL, S_RELEASE: cnt_q <= cnt_q + CW'(1);
				S_IDLE: begin
					if (accept) begin
						if (req.func == FN_FREE) begin
							cnt_q <= CW'(req.slot_index);
						end else begin
							cnt_q <= '0;
						end
						if (req.func == FN_CLEAR) used_q <= '0;
					end
				end
				S_SCAN: begin
					rd_pend_q <= scan_issue;
					if (hit) begin
						cnt_q <= {1'b0, hit_start};
						if (hit_end > used_q) used_q <= hit_end;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Payload and scan bookkeeping; these need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					run_q     <= '0;
					granted_q <= '0;
					lenm1_q   <= tag_len_m1(req.run_size + 2'd1);
					code_q    <= req.run_size + 2'd1;
					case (req.func)
						FN_ALLOC: status_q <= ST_NOSPACE;
						FN_FREE:  status_q <= idx_ok ? ST_OK : ST_NOTALLOC;
						default:  status_q <= ST_OK;
					endcase
				end
			end
			S_SCAN: begin
				run_q     <= run_nx;
				rd_addr_q <= cnt_q[AW-1:0];
				rem_q     <= lenm1_q;
				if (hit) begin
					granted_q <= 8'(hit_start);
					status_q  <= ST_OK;
				end
			end
			S_FILL, S_RELEASE: rem_q <= rem_q - 2'd1;
			S_CHECK: begin
				rem_q <= tag_len_m1(ram_rdata);
				if (ram_rdata == TAG_FREE) status_q <= ST_NOTALLOC;
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_q.granted_index <= granted_q;
			rsp_q.status        <= status_q;
			rsp_q.high_water    <= 9'(used_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== src/ffsa_checker.sv =====
module ffsa_checker import ffsa_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input ffsa_req_t req,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input ffsa_rsp_t rsp
);

	// Items accepted whose result has not yet been taken.
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed or dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready again right after an accepted item");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pend_q != 2'd0) && (pend_q <= 2'd2))
		else $error("result without a matching item, or too many in flight");

	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> rsp.granted_index == 8'd0)
		else $error("failed item reports a granted index");

endmodule

bind first_fit_slot_allocator_unit ffsa_checker u_ffsa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
